FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the translation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlbpt_pkg.sv
// Package with the types and constants of the TLB page translation block.
`default_nettype none

package tlbpt_pkg;

  // Default sizes of the configurable stores.
  localparam int unsigned TLB_ENTRIES_DEF   = 16;
  localparam int unsigned PAGE_ENTRIES_DEF  = 256;
  localparam int unsigned FRAME_ENTRIES_DEF = 32768;
  localparam int unsigned OFFSET_BITS_DEF   = 8;

  // Fixed field widths of the words on the ports.
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned PAGE_W      = 8;
  localparam int unsigned PAGE_SPAN   = 256;
  localparam int unsigned PA_W        = 23;
  localparam int unsigned FRAME_OUT_W = 15;
  localparam int unsigned CNT_W       = 32;

  // Control sequence of the translation core.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/tlb_page_translation_core.sv
// Top level of the TLB page translation block: TLB, page table memory and control.
`default_nettype none

// Usage
// An address word is offered on in_logical_address with start; it is taken at
// a rising clk edge where start is high and busy is low. The block splits it
// into an 8-bit page and an offset, searches the fully associative TLB and,
// on a miss, the page table. A page with no frame yet takes the next free
// frame (a page fault), and every miss installs the pair into the TLB slot
// under the FIFO replacement pointer.
// The result word appears on the out_ ports with out_valid in the cycle after
// the lookup cycle and holds for one cycle. busy is high during the lookup
// cycle, in which the page table word read at the accepting edge comes back
// from the synchronous memory, so no new word is taken until that cycle ends.
// The receiver cannot stall: out_valid lasts one cycle and the next word can
// be accepted in that same cycle.
// Reset (synchronous, rst_n low) clears the TLB valid bits, the counters and
// the pointers, then a clearing pass writes every page table row invalid,
// one row per cycle; busy stays high during it.
module tlb_page_translation_core
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES   = TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_ENTRIES  = PAGE_ENTRIES_DEF,
  parameter int unsigned FRAME_ENTRIES = FRAME_ENTRIES_DEF,
  parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [ADDR_W-1:0]      in_logical_address,
  output logic                        out_valid,
  output logic [PA_W-1:0]             out_physical_address,
  output logic [FRAME_OUT_W-1:0]      out_frame_index,
  output logic                        out_tlb_hit,
  output logic                        out_page_fault,
  output logic [PAGE_W-1:0]           out_fault_page,
  output logic [CNT_W-1:0]            out_hits_so_far,
  output logic [CNT_W-1:0]            out_misses_so_far,
  output logic [CNT_W-1:0]            out_faults_so_far
);

  // Index and storage widths derived from the sizes.
  localparam int unsigned TLB_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned ROW_W   = $clog2(PAGE_ENTRIES);
  localparam int unsigned FRAME_W = $clog2(FRAME_ENTRIES);
  localparam int unsigned MEM_W   = FRAME_W + 1;

  // Page number to table row. For a table smaller than the page space the
  // row wraps; the table is built at elaboration by a running counter.
  typedef logic [ROW_W-1:0] row_tbl_t [PAGE_SPAN];

  function automatic row_tbl_t build_rows();
    row_tbl_t    t;
    int unsigned r;
    r = 0;
    for (int unsigned p = 0; p < PAGE_SPAN; p++) begin
      t[p] = ROW_W'(r);
      r = r + 1;
      if (r == PAGE_ENTRIES) begin
        r = 0;
      end
    end
    return t;
  endfunction

  localparam row_tbl_t ROW_TBL = build_rows();

  // Control state.
  state_t                 state_r, state_nxt;
  logic [ROW_W-1:0]       clr_r;
  logic [TLB_W-1:0]       rp_r, rp_nxt;
  logic [FRAME_W-1:0]     free_frame_r, free_frame_nxt;
  logic [CNT_W-1:0]       hit_total_r, hit_total_nxt;
  logic [CNT_W-1:0]       miss_total_r, miss_total_nxt;
  logic [CNT_W-1:0]       fault_total_r, fault_total_nxt;
  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic                   out_valid_r;

  // Payload registers.
  logic [PAGE_W-1:0]      page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [ROW_W-1:0]       row_r;
  logic [PAGE_W-1:0]      tlb_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_r [TLB_ENTRIES];
  logic [PA_W-1:0]        pa_r;
  logic [FRAME_OUT_W-1:0] frame_out_r;
  logic                   hit_out_r;
  logic                   fault_out_r;
  logic [PAGE_W-1:0]      fault_page_r;

  // Page table memory: one word per row holds a valid flag and the frame.
  logic [MEM_W-1:0]       pt_mem [PAGE_ENTRIES];
  logic [MEM_W-1:0]       mem_rdata_r;
  logic                   mem_we;
  logic [ROW_W-1:0]       mem_waddr;
  logic [MEM_W-1:0]       mem_wdata;

  // Input split.
  logic                   accept;
  logic [ADDR_W-1:0]      addr_shift;
  logic [PAGE_W-1:0]      in_page;

  // Lookup results.
  logic                   tlb_hit;
  logic [FRAME_W-1:0]     tlb_hit_frame;
  logic                   look_fault;
  logic [FRAME_W-1:0]     look_frame;

  assign accept     = start && !busy;
  assign addr_shift = in_logical_address >> OFFSET_BITS;
  assign in_page    = addr_shift[PAGE_W-1:0];
  assign busy       = (state_r != ST_IDLE);

  // Parallel compare across the TLB; scanning downward lets the
  // lowest-numbered matching entry win.
  always_comb begin
    tlb_hit       = 1'b0;
    tlb_hit_frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_r[i] && (tlb_page_r[i] == page_r)) begin
        tlb_hit       = 1'b1;
        tlb_hit_frame = tlb_frame_r[i];
      end
    end
  end

  // Next state, memory write port and counter updates.
  always_comb begin
    state_nxt       = state_r;
    rp_nxt          = rp_r;
    free_frame_nxt  = free_frame_r;
    hit_total_nxt   = hit_total_r;
    miss_total_nxt  = miss_total_r;
    fault_total_nxt = fault_total_r;
    mem_we          = 1'b0;
    mem_waddr       = row_r;
    mem_wdata       = '0;
    look_fault      = 1'b0;
    look_frame      = tlb_hit_frame;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        if (clr_r == ROW_W'(PAGE_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
        if (tlb_hit) begin
          hit_total_nxt = hit_total_r + 1'b1;
        end else begin
          miss_total_nxt = miss_total_r + 1'b1;
          if (mem_rdata_r[FRAME_W]) begin
            look_frame = mem_rdata_r[FRAME_W-1:0];
          end else begin
            look_fault      = 1'b1;
            look_frame      = free_frame_r;
            fault_total_nxt = fault_total_r + 1'b1;
            free_frame_nxt  = (free_frame_r == FRAME_W'(FRAME_ENTRIES - 1)) ?
                              '0 : free_frame_r + 1'b1;
            mem_we          = 1'b1;
            mem_wdata       = {1'b1, free_frame_r};
          end
          rp_nxt = (rp_r == TLB_W'(TLB_ENTRIES - 1)) ? '0 : rp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      rp_r          <= '0;
      free_frame_r  <= '0;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      fault_total_r <= '0;
      tlb_valid_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= (state_r == ST_CLEAR) ? clr_r + 1'b1 : clr_r;
      rp_r          <= rp_nxt;
      free_frame_r  <= free_frame_nxt;
      hit_total_r   <= hit_total_nxt;
      miss_total_r  <= miss_total_nxt;
      fault_total_r <= fault_total_nxt;
      out_valid_r   <= (state_r == ST_LOOK);
      if ((state_r == ST_LOOK) && !tlb_hit) begin
        tlb_valid_r[rp_r] <= 1'b1;
      end
    end
  end

  // Payload registers: captured address, TLB contents and the result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r   <= in_page;
      offset_r <= in_logical_address[OFFSET_BITS-1:0];
      row_r    <= ROW_TBL[in_page];
    end
    if ((state_r == ST_LOOK) && !tlb_hit) begin
      tlb_page_r[rp_r]  <= page_r;
      tlb_frame_r[rp_r] <= look_frame;
    end
    if (state_r == ST_LOOK) begin
      pa_r         <= PA_W'({{PA_W{1'b0}}, look_frame, offset_r});
      frame_out_r  <= FRAME_OUT_W'({{FRAME_OUT_W{1'b0}}, look_frame});
      hit_out_r    <= tlb_hit;
      fault_out_r  <= look_fault;
      fault_page_r <= look_fault ? page_r : '0;
    end
  end

  // Page table memory. The row is read at the accepting edge and used in
  // the lookup cycle; its write back lands before the next read can start.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata_r <= pt_mem[ROW_TBL[in_page]];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = pa_r;
  assign out_frame_index      = frame_out_r;
  assign out_tlb_hit          = hit_out_r;
  assign out_page_fault       = fault_out_r;
  assign out_fault_page       = fault_page_r;
  assign out_hits_so_far      = hit_total_r;
  assign out_misses_so_far    = miss_total_r;
  assign out_faults_so_far    = fault_total_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_to_look, accept, state_r == ST_LOOK, "accepted word did not enter lookup")
  `ASSERT_NEXT(a_look_to_result, state_r == ST_LOOK, out_valid, "lookup gave no result strobe")
  `ASSERT_NOW(a_hit_not_fault, out_valid, !(out_tlb_hit && out_page_fault), "hit and fault together")
  `ASSERT_NEXT(a_fault_takes_frame, look_fault, free_frame_r != $past(free_frame_r), "fault kept frame")

endmodule

`default_nettype wire

FILE: sim/tb_tlb_page_translation_core.sv
// Self-checking testbench for the TLB page translation core: directed table, then random traffic.
`default_nettype none

module tb_tlb_page_translation_core;
  import tlbpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog gives up after this many cycles in which no word moves on
  // either side; the limit has to cover reset, the page table clearing pass
  // and the longest sender gap.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS = 850;

  // One result word as the block reports it.
  typedef struct packed {
    logic [PA_W-1:0]        pa;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   hit;
    logic                   fault;
    logic [PAGE_W-1:0]      fault_page;
    logic [CNT_W-1:0]       hits;
    logic [CNT_W-1:0]       misses;
    logic [CNT_W-1:0]       faults;
  } xlate_word_t;

  // One row of the directed table. When has_known is set, the row carries a
  // result that can be read straight off the behavior; otherwise the
  // predicted translation is expected.
  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                has_known;
    xlate_word_t       known;
  } addr_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic [ADDR_W-1:0]      in_logical_address = '0;
  logic                   busy;
  logic                   out_valid;
  logic [PA_W-1:0]        out_physical_address;
  logic [FRAME_OUT_W-1:0] out_frame_index;
  logic                   out_tlb_hit;
  logic                   out_page_fault;
  logic [PAGE_W-1:0]      out_fault_page;
  logic [CNT_W-1:0]       out_hits_so_far;
  logic [CNT_W-1:0]       out_misses_so_far;
  logic [CNT_W-1:0]       out_faults_so_far;

  tlb_page_translation_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_logical_address   (in_logical_address),
    .out_valid            (out_valid),
    .out_physical_address (out_physical_address),
    .out_frame_index      (out_frame_index),
    .out_tlb_hit          (out_tlb_hit),
    .out_page_fault       (out_page_fault),
    .out_fault_page       (out_fault_page),
    .out_hits_so_far      (out_hits_so_far),
    .out_misses_so_far    (out_misses_so_far),
    .out_faults_so_far    (out_faults_so_far)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Translations still owed by the block, oldest first.
  xlate_word_t pending_xlates[$];
  int          error_count = 0;
  int          quiet_cycles = 0;

  // Shadow copy of the translation state: the TLB, the page map, the FIFO
  // replacement pointer, the free frame counter and the running totals.
  bit                     tlb_ok  [TLB_ENTRIES_DEF];
  logic [PAGE_W-1:0]      tlb_pg  [TLB_ENTRIES_DEF];
  logic [FRAME_OUT_W-1:0] tlb_frm [TLB_ENTRIES_DEF];
  bit                     map_ok  [PAGE_ENTRIES_DEF];
  logic [FRAME_OUT_W-1:0] map_frm [PAGE_ENTRIES_DEF];
  int unsigned            fifo_slot = 0;
  logic [FRAME_OUT_W-1:0] next_frame = '0;
  logic [CNT_W-1:0]       hit_count = '0;
  logic [CNT_W-1:0]       miss_count = '0;
  logic [CNT_W-1:0]       fault_count = '0;

  // Translates one address and advances the shadow state, exactly as the
  // block does for an accepted word.
  function automatic xlate_word_t translate_address(input logic [ADDR_W-1:0] addr);
    xlate_word_t                w;
    logic [PAGE_W-1:0]          page;
    logic [OFFSET_BITS_DEF-1:0] offset;
    logic [FRAME_OUT_W-1:0]     frame;
    bit                         found;
    int unsigned                row;
    int                         i;
    page = PAGE_W'(addr >> OFFSET_BITS_DEF);
    offset = addr[OFFSET_BITS_DEF-1:0];
    found = 1'b0;
    frame = '0;
    w = '0;
    // The lowest numbered valid entry that holds the page wins.
    for (i = 0; i < TLB_ENTRIES_DEF; i++) begin
      if (!found && tlb_ok[i] && tlb_pg[i] == page) begin
        found = 1'b1;
        frame = tlb_frm[i];
      end
    end
    if (found) begin
      hit_count++;
    end else begin
      row = page % PAGE_ENTRIES_DEF;
      miss_count++;
      if (map_ok[row]) begin
        frame = map_frm[row];
      end else begin
        // First touch of the page: it takes the next free frame.
        w.fault = 1'b1;
        w.fault_page = page;
        fault_count++;
        frame = next_frame;
        next_frame = FRAME_OUT_W'((next_frame + 1) % FRAME_ENTRIES_DEF);
        map_ok[row] = 1'b1;
        map_frm[row] = frame;
      end
      // Every miss refills the TLB slot under the FIFO pointer.
      tlb_ok[fifo_slot] = 1'b1;
      tlb_pg[fifo_slot] = page;
      tlb_frm[fifo_slot] = frame;
      fifo_slot = (fifo_slot + 1) % TLB_ENTRIES_DEF;
    end
    w.pa = PA_W'({frame, offset});
    w.frame = frame;
    w.hit = found;
    w.hits = hit_count;
    w.misses = miss_count;
    w.faults = fault_count;
    return w;
  endfunction

  function automatic addr_row_t make_row(input logic [ADDR_W-1:0] addr, input bit has_known,
                                         input xlate_word_t known);
    addr_row_t r;
    r.addr = addr;
    r.has_known = has_known;
    r.known = known;
    return r;
  endfunction

  // Offers one address word and holds it until the block takes it. Called
  // at a falling edge, returns at the falling edge after acceptance with
  // start still high, so a following word can go out back to back.
  task automatic send_word(input logic [ADDR_W-1:0] addr, input bit has_known,
                           input xlate_word_t known);
    xlate_word_t predicted;
    in_logical_address <= addr;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = translate_address(addr);
    pending_xlates.push_back(has_known ? known : predicted);
    @(negedge clk);
  endtask

  // Picks a random address. Most of the traffic stays on a few hot pages,
  // which mostly hit, or on a working set wider than the TLB, which keeps
  // the FIFO replacement busy with misses that find their page mapped. The
  // rest is fully random and fills the page table with faults.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       pick;
    logic [PAGE_W-1:0] page;
    pick = $urandom_range(99);
    if (pick < 40) begin
      page = PAGE_W'($urandom_range(7));
    end else if (pick < 70) begin
      page = PAGE_W'($urandom_range(63, 40));
    end else begin
      return ADDR_W'($urandom);
    end
    return {page, OFFSET_BITS_DEF'($urandom)};
  endfunction

  // Compares one field of a result word and reports a mismatch.
  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Result checker. The receiver cannot hold results off, so every cycle
  // with out_valid high delivers one word that must match the oldest
  // outstanding translation.
  always @(posedge clk) begin
    xlate_word_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_xlates.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result word, expected none, actual address %0h",
                 $time, out_physical_address);
      end else begin
        want = pending_xlates.pop_front();
        check_field("physical_address", CNT_W'(want.pa), CNT_W'(out_physical_address));
        check_field("frame_index", CNT_W'(want.frame), CNT_W'(out_frame_index));
        check_field("tlb_hit", CNT_W'(want.hit), CNT_W'(out_tlb_hit));
        check_field("page_fault", CNT_W'(want.fault), CNT_W'(out_page_fault));
        check_field("fault_page", CNT_W'(want.fault_page), CNT_W'(out_fault_page));
        check_field("hits_so_far", want.hits, out_hits_so_far);
        check_field("misses_so_far", want.misses, out_misses_so_far);
        check_field("faults_so_far", want.faults, out_faults_so_far);
      end
    end
  end

  // Watchdog: counts cycles in which neither an address word nor a result
  // word moves, and ends the run when the block appears hung.
  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_tlb_page_translation_core failed");
        $finish;
      end
    end
  end

  initial begin
    addr_row_t   addr_rows[$];
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          drained;
    int          i;

    // Directed table. The first rows run from a cold TLB and an empty page
    // table, so their results follow directly: a fault on page 0x00 gets
    // frame 0, a hit on the same page, a fault on page 0xFF gets frame 1 and
    // a hit on it, covering both ends of the offset and the page range.
    addr_rows.push_back(make_row(16'h0000, 1'b1,
                                 '{23'h000000, 15'd0, 1'b0, 1'b1, 8'h00, 0, 1, 1}));
    addr_rows.push_back(make_row(16'h00FF, 1'b1,
                                 '{23'h0000FF, 15'd0, 1'b1, 1'b0, 8'h00, 1, 1, 1}));
    addr_rows.push_back(make_row(16'hFFFF, 1'b1,
                                 '{23'h0001FF, 15'd1, 1'b0, 1'b1, 8'hFF, 1, 2, 2}));
    addr_rows.push_back(make_row(16'hFF00, 1'b1,
                                 '{23'h000100, 15'd1, 1'b1, 1'b0, 8'h00, 2, 2, 2}));
    // Sixteen new pages wrap the FIFO pointer and push pages 0x00 and 0xFF
    // out of the TLB.
    for (i = 1; i <= 16; i++) begin
      addr_rows.push_back(make_row({PAGE_W'(i), OFFSET_BITS_DEF'(i * 37)}, 1'b0, '0));
    end
    // Evicted pages now miss in the TLB but find their frame in the table.
    addr_rows.push_back(make_row(16'h0080, 1'b1,
                                 '{23'h000080, 15'd0, 1'b0, 1'b0, 8'h00, 2, 19, 18}));
    addr_rows.push_back(make_row(16'hFF80, 1'b1,
                                 '{23'h000180, 15'd1, 1'b0, 1'b0, 8'h00, 2, 20, 18}));
    // A page installed late in the sweep still hits, and one of the first
    // pages of the sweep has been replaced by the refills above.
    addr_rows.push_back(make_row(16'h10AA, 1'b0, '0));
    addr_rows.push_back(make_row(16'h0155, 1'b0, '0));

    // Reset is held low, then released. The block then clears its page table
    // on its own, with busy high, and the first word simply waits for it.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (addr_rows[k]) begin
      send_word(addr_rows[k].addr, addr_rows[k].has_known, addr_rows[k].known);
    end

    // Random traffic in bursts. Gaps of odd and even length land on both the
    // idle and the lookup state of the block, and once midway the sender holds
    // off until every outstanding translation has come back.
    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      for (i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        send_word(pick_address(), 1'b0, '0);
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (!drained && sent >= RANDOM_WORDS / 2) begin
        gap = (gap == 0) ? 1 : gap;
      end
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
        if (!drained && sent >= RANDOM_WORDS / 2) begin
          wait (pending_xlates.size() == 0);
          @(negedge clk);
          drained = 1'b1;
        end
      end
    end
    start <= 1'b0;

    // Let the last translations come back, then keep the clock running so that
    // a stray result word would still be caught.
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_tlb_page_translation_core passed");
    end else begin
      $display("tb_tlb_page_translation_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
